FILE: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared widths, state codes and divider handshake types for the linear
// congruence solver.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  // Width of each operand field a, b and m.
  localparam int unsigned DW = 31;
  // Signed width of the Bezout coefficients; their magnitude stays below m.
  localparam int unsigned SW = DW + 2;
  // Width of the final product and of the divider's dividend.
  localparam int unsigned PW = 64;
  // Width of the signed solution field.
  localparam int unsigned SOL_W = 32;
  // Divider step counter, able to hold PW itself.
  localparam int unsigned CNT_W = $clog2(PW + 1);

  // Stream widths: fields packed from bit 0 up, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = ((3 * DW + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((SOL_W + 7) / 8) * 8;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_EUC_CHK = 10'b00_0000_0010,
    ST_EUC_DIV = 10'b00_0000_0100,
    ST_EUC_MUL = 10'b00_0000_1000,
    ST_EUC_UPD = 10'b00_0001_0000,
    ST_GCD_DIV = 10'b00_0010_0000,
    ST_FIN_MUL = 10'b00_0100_0000,
    ST_MOD_GO  = 10'b00_1000_0000,
    ST_MOD_DIV = 10'b01_0000_0000,
    ST_FIN     = 10'b10_0000_0000
  } lcs_state_e;

  // Request to the shared divider. A narrow request divides a DW-bit value
  // in DW steps; a wide request divides the full PW-bit dividend.
  typedef struct packed {
    logic          start;
    logic          wide;
    logic [PW-1:0] dividend;
    logic [DW-1:0] divisor;
  } lcs_div_req_t;

  // Divider result; quotient and remainder hold until the next start.
  typedef struct packed {
    logic          done;
    logic [PW-1:0] quotient;
    logic [DW-1:0] remainder;
  } lcs_div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/lcs_div.sv
// ----------------------------------------------------------------------------
// lcs_div
// Shared radix-2 restoring divider: one quotient bit per cycle, unsigned
// dividend of up to PW bits over a nonzero DW-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lcs_pkg::lcs_div_req_t req_i,
  output lcs_pkg::lcs_div_rsp_t      rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [lcs_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [lcs_pkg::PW-1:0]        quo_q, quo_d;
  logic [lcs_pkg::DW-1:0]        rem_q, rem_d;
  logic [lcs_pkg::DW-1:0]        dvs_q, dvs_d;
  logic [lcs_pkg::DW:0]          trial;
  logic [lcs_pkg::DW:0]          diff;
  logic                          qbit;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[lcs_pkg::PW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  // Load on start, otherwise step while busy.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      if (req_i.wide) begin
        cnt_d = lcs_pkg::CNT_W'(lcs_pkg::PW);
        quo_d = req_i.dividend;
      end else begin
        // Align the narrow dividend to the top so its bits leave first.
        cnt_d = lcs_pkg::CNT_W'(lcs_pkg::DW);
        quo_d = {req_i.dividend[lcs_pkg::DW-1:0], {(lcs_pkg::PW - lcs_pkg::DW){1'b0}}};
      end
    end else if (busy_q) begin
      quo_d = {quo_q[lcs_pkg::PW-2:0], qbit};
      rem_d = qbit ? diff[lcs_pkg::DW-1:0] : trial[lcs_pkg::DW-1:0];
      cnt_d = cnt_q - lcs_pkg::CNT_W'(1);
      if (cnt_q == lcs_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

FILE: rtl/linear_congruence_solver.sv
// ----------------------------------------------------------------------------
// linear_congruence_solver
// Solves a*x = b (mod m) with an iterative extended Euclid on one shared
// divider and one registered multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat carries one query (a, b, m) on the slave stream. The
//   block then runs extended Euclid on (a, m); each Euclid step runs one
//   narrow division of 31 quotient bits on the shared radix-2 divider,
//   then a multiply and a coefficient update. After the loop, b is divided
//   by the gcd; if that leaves a remainder the query is flagged
//   unsolvable. Otherwise the quotient times the Bezout coefficient is
//   formed and reduced mod m on a wide division of the full product; a
//   zero modulus skips the loop and is answered as unsolvable.
//   The divider bounds the rate: one query is in work at a time, and
//   s_axis_tready_o is high only while the sequencer is idle.
//   Each query yields exactly one output beat: tuser = solvable, tdata =
//   signed solution (0 when unsolvable). The result sits in an output
//   register, so the next query is accepted while it waits; a stalled
//   receiver holds the finished answer of the following query back.
//   Reset clears the sequencer and the output valid; no query is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_congruence_solver (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Query stream.
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata, from bit 0: coef_a, target_b, modulus_m, zero padding.
  input  wire logic [lcs_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // Result stream.
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata, from bit 0: solution.
  output logic [lcs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,
  // tuser, from bit 0: solvable.
  output logic [0:0]                              m_axis_tuser_o
);

  localparam int unsigned DW = lcs_pkg::DW;
  localparam int unsigned SW = lcs_pkg::SW;
  localparam int unsigned PW = lcs_pkg::PW;
  localparam int unsigned SOL_W = lcs_pkg::SOL_W;

  lcs_pkg::lcs_state_e          state_q, state_d;
  logic [DW-1:0]                b_q, b_d;
  logic [DW-1:0]                m_q, m_d;
  logic [DW-1:0]                r0_q, r0_d;
  logic [DW-1:0]                r1_q, r1_d;
  logic signed [SW-1:0]         s0_q, s0_d;
  logic signed [SW-1:0]         s1_q, s1_d;
  logic [PW-1:0]                prod_q, prod_d;
  logic                         neg_q, neg_d;
  logic                         res_solv_q, res_solv_d;
  logic [SOL_W-1:0]             res_sol_q, res_sol_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_solv_q, out_solv_d;
  logic [SOL_W-1:0]             out_sol_q, out_sol_d;

  logic                         in_fire;
  logic                         out_free;
  logic [DW-1:0]                in_a, in_b, in_m;
  logic signed [SW-1:0]         mul_b;
  logic signed [DW+SW:0]        mul_full;
  logic [PW-1:0]                prod_mag;
  logic [PW-1:0]                rem_ext;
  logic [PW-1:0]                rem_neg;

  lcs_pkg::lcs_div_req_t        div_req;
  lcs_pkg::lcs_div_rsp_t        div_rsp;

  // Shared divider.
  lcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Unpack the query beat.
  assign in_a = s_axis_tdata_i[DW-1:0];
  assign in_b = s_axis_tdata_i[2*DW-1:DW];
  assign in_m = s_axis_tdata_i[3*DW-1:2*DW];

  assign s_axis_tready_o = (state_q == lcs_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Multiplier: latest quotient times a Bezout coefficient.
  assign mul_b    = (state_q == lcs_pkg::ST_FIN_MUL) ? s0_q : s1_q;
  assign mul_full = (DW+SW+1)'($signed({2'b00, div_rsp.quotient[DW-1:0]}) * mul_b);

  // Magnitude of the product and sign restore of the final remainder.
  assign prod_mag = prod_q[PW-1] ? (PW'(0) - prod_q) : prod_q;
  assign rem_ext  = PW'(div_rsp.remainder);
  assign rem_neg  = PW'(0) - rem_ext;

  // Sequencer and datapath next state.
  always_comb begin
    state_d    = state_q;
    b_d        = b_q;
    m_d        = m_q;
    r0_d       = r0_q;
    r1_d       = r1_q;
    s0_d       = s0_q;
    s1_d       = s1_q;
    prod_d     = prod_q;
    neg_d      = neg_q;
    res_solv_d = res_solv_q;
    res_sol_d  = res_sol_q;

    div_req.start    = 1'b0;
    div_req.wide     = 1'b0;
    div_req.dividend = PW'(r0_q);
    div_req.divisor  = r1_q;

    case (state_q)
      lcs_pkg::ST_IDLE: begin
        if (in_fire) begin
          b_d  = in_b;
          m_d  = in_m;
          r0_d = in_a;
          r1_d = in_m;
          s0_d = SW'(1);
          s1_d = '0;
          if (in_m == '0) begin
            // A zero modulus has no answer.
            res_solv_d = 1'b0;
            res_sol_d  = '0;
            state_d    = lcs_pkg::ST_FIN;
          end else begin
            state_d = lcs_pkg::ST_EUC_CHK;
          end
        end
      end
      lcs_pkg::ST_EUC_CHK: begin
        div_req.start = 1'b1;
        if (r1_q != '0) begin
          state_d = lcs_pkg::ST_EUC_DIV;
        end else begin
          // Euclid is finished: r0 holds the gcd; test whether it divides b.
          div_req.dividend = PW'(b_q);
          div_req.divisor  = r0_q;
          state_d          = lcs_pkg::ST_GCD_DIV;
        end
      end
      lcs_pkg::ST_EUC_DIV: begin
        if (div_rsp.done) begin
          state_d = lcs_pkg::ST_EUC_MUL;
        end
      end
      lcs_pkg::ST_EUC_MUL: begin
        prod_d  = PW'(mul_full);
        state_d = lcs_pkg::ST_EUC_UPD;
      end
      lcs_pkg::ST_EUC_UPD: begin
        r0_d    = r1_q;
        r1_d    = div_rsp.remainder;
        s0_d    = s1_q;
        s1_d    = s0_q - $signed(prod_q[SW-1:0]);
        state_d = lcs_pkg::ST_EUC_CHK;
      end
      lcs_pkg::ST_GCD_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder != '0) begin
            res_solv_d = 1'b0;
            res_sol_d  = '0;
            state_d    = lcs_pkg::ST_FIN;
          end else begin
            state_d = lcs_pkg::ST_FIN_MUL;
          end
        end
      end
      lcs_pkg::ST_FIN_MUL: begin
        prod_d  = PW'(mul_full);
        state_d = lcs_pkg::ST_MOD_GO;
      end
      lcs_pkg::ST_MOD_GO: begin
        // Reduce the magnitude; the sign is put back afterward.
        div_req.start    = 1'b1;
        div_req.wide     = 1'b1;
        div_req.dividend = prod_mag;
        div_req.divisor  = m_q;
        neg_d            = prod_q[PW-1];
        state_d          = lcs_pkg::ST_MOD_DIV;
      end
      lcs_pkg::ST_MOD_DIV: begin
        if (div_rsp.done) begin
          res_solv_d = 1'b1;
          res_sol_d  = neg_q ? rem_neg[SOL_W-1:0] : rem_ext[SOL_W-1:0];
          state_d    = lcs_pkg::ST_FIN;
        end
      end
      lcs_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = lcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcs_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: load the finished answer once the previous beat left.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_solv_d  = out_solv_q;
    out_sol_d   = out_sol_q;
    if ((state_q == lcs_pkg::ST_FIN) && out_free) begin
      out_valid_d = 1'b1;
      out_solv_d  = res_solv_q;
      out_sol_d   = res_sol_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    b_q        <= b_d;
    m_q        <= m_d;
    r0_q       <= r0_d;
    r1_q       <= r1_d;
    s0_q       <= s0_d;
    s1_q       <= s1_d;
    prod_q     <= prod_d;
    neg_q      <= neg_d;
    res_solv_q <= res_solv_d;
    res_sol_q  <= res_sol_d;
    out_solv_q <= out_solv_d;
    out_sol_q  <= out_sol_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = lcs_pkg::OUT_TDATA_W'(out_sol_q);
  assign m_axis_tuser_o  = out_solv_q;

endmodule

`default_nettype wire
